// ===== design/pcys_pkg.sv =====
// Shared types, constants and conversion helpers for the palette-to-YUV
// chroma subsampling unit. No dependencies.
package pcys_pkg;

  localparam int COMP_W   = 8;
  localparam int SIDE_CFG_W = 3;
  localparam int SUM_W    = 12;
  localparam int RCP_SHIFT = 19;
  localparam int RCP_W    = RCP_SHIFT + 1;
  localparam int PROD_W   = SUM_W + RCP_W;
  localparam int QUO_W    = PROD_W - RCP_SHIFT;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int CONV_W   = 18;

  localparam logic [SIDE_CFG_W-1:0] CELL_SIDE_RST = 3'd2;

  localparam logic CFG_CELL_WIDTH  = 1'b0;
  localparam logic CFG_CELL_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  localparam logic signed [CONV_W-1:0] KY_R = 18'sd77;
  localparam logic signed [CONV_W-1:0] KY_G = 18'sd150;
  localparam logic signed [CONV_W-1:0] KY_B = 18'sd29;
  localparam logic signed [CONV_W-1:0] KU_R = -18'sd44;
  localparam logic signed [CONV_W-1:0] KU_G = -18'sd87;
  localparam logic signed [CONV_W-1:0] KU_B = 18'sd131;
  localparam logic signed [CONV_W-1:0] KV_R = 18'sd131;
  localparam logic signed [CONV_W-1:0] KV_G = -18'sd110;
  localparam logic signed [CONV_W-1:0] KV_B = -18'sd21;
  localparam logic signed [CONV_W-1:0] CHROMA_BIAS = 18'sd128;

  typedef struct packed {
    logic              wr;
    logic [COMP_W-1:0] addr;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic [COMP_W-1:0] v;
    logic [COMP_W-1:0] u;
    logic [COMP_W-1:0] y;
  } yuv_t;

  // n / 256 truncated toward zero, optional +128, clamped to 0..255
  function automatic logic [COMP_W-1:0] scale_clamp(input logic signed [CONV_W-1:0] n,
                                                    input logic bias);
    logic signed [CONV_W-1:0] mag;
    logic signed [CONV_W-1:0] q;
    logic signed [CONV_W-1:0] s;
    mag = (n < 0) ? -n : n;
    q = mag >>> 8;
    if (n < 0) begin
      q = -q;
    end
    s = bias ? (q + CHROMA_BIAS) : q;
    if (s < 0) begin
      return '0;
    end else if (s > 18'sd255) begin
      return '1;
    end
    return s[COMP_W-1:0];
  endfunction

  function automatic yuv_t rgb_to_yuv(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                                      input logic [COMP_W-1:0] b);
    logic signed [CONV_W-1:0] rs;
    logic signed [CONV_W-1:0] gs;
    logic signed [CONV_W-1:0] bs;
    yuv_t res;
    rs = $signed({{(CONV_W-COMP_W){1'b0}}, r});
    gs = $signed({{(CONV_W-COMP_W){1'b0}}, g});
    bs = $signed({{(CONV_W-COMP_W){1'b0}}, b});
    res.y = scale_clamp(KY_R * rs + KY_G * gs + KY_B * bs, 1'b0);
    res.u = scale_clamp(KU_R * rs + KU_G * gs + KU_B * bs, 1'b1);
    res.v = scale_clamp(KV_R * rs + KV_G * gs + KV_B * bs, 1'b1);
    return res;
  endfunction

endpackage

// ===== design/pcys_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcys_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pcys_queue.sv =====
// Short request queue between the front and back parts.
// Depends on pcys_pkg.
module pcys_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pcys_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pcys_pkg::entry_t pop_data
);
  import pcys_pkg::*;

  entry_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != (Q_PTR_W+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== design/pcys_front.sv =====
// Input stage: accepts stream items, classifies palette writes and pixels,
// reduces the table address and hands a request to the queue. Depends on pcys_pkg.
module pcys_front #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [39:0]      in_tdata,
  input  logic             in_tuser,
  input  logic             in_tlast,
  output logic             push_valid,
  input  logic             push_ready,
  output pcys_pkg::entry_t push_data
);
  import pcys_pkg::*;

  logic [COMP_W-1:0] mod_tbl [2**COMP_W];
  logic              vld_r, vld_nxt;
  entry_t            entry_r;
  logic              take;
  logic [COMP_W-1:0] raw_addr;

  for (genvar g = 0; g < 2**COMP_W; g++) begin : g_mod
    assign mod_tbl[g] = COMP_W'(g % PALETTE_ENTRIES);
  end

  assign in_tready  = ~vld_r | push_ready;
  assign take       = in_tvalid & in_tready;
  assign raw_addr   = (in_tuser == OP_PAL_WRITE) ? in_tdata[7:0] : in_tdata[39:32];
  assign push_valid = vld_r;
  assign push_data  = entry_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_r.wr    <= (in_tuser == OP_PAL_WRITE);
      entry_r.addr  <= mod_tbl[raw_addr];
      entry_r.red   <= in_tdata[15:8];
      entry_r.green <= in_tdata[23:16];
      entry_r.blue  <= in_tdata[31:24];
      entry_r.last  <= in_tlast;
    end
  end

endmodule

// ===== design/pcys_back.sv =====
// Execution pipeline: palette conversion and table write, pixel lookup,
// chroma accumulation, cell average by reciprocal multiply and result register.
// Depends on pcys_pkg and pcys_ram.
module pcys_back #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_CELL_SIDE   = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [pcys_pkg::SIDE_CFG_W-1:0]    cell_width,
  input  logic [pcys_pkg::SIDE_CFG_W-1:0]    cell_height,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  pcys_pkg::entry_t                   pop_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,
  output logic                               out_tuser
);
  import pcys_pkg::*;

  localparam int IDX_W    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int SIDE_W   = $clog2(MAX_CELL_SIDE + 1);
  localparam int AREA_MAX = MAX_CELL_SIDE * MAX_CELL_SIDE;
  localparam int AREA_W   = $clog2(AREA_MAX + 1);

  logic [RCP_W-1:0]  rcp_tbl [AREA_MAX + 1];
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [AREA_W-1:0] area;
  logic              chroma_en;
  logic [RCP_W-1:0]  rcp_r;

  logic              adv, pop;
  yuv_t              conv;
  yuv_t              rd;

  logic              s1_vld_r, s1_last_r;
  logic [SUM_W-1:0]  u_sum_r, u_sum_nxt, v_sum_r, v_sum_nxt;
  logic [SUM_W:0]    u_add, v_add;
  logic [SUM_W-1:0]  u_acc, v_acc;

  logic              s2_vld_r, s2_cv_r;
  logic [COMP_W-1:0] s2_y_r;
  logic [SUM_W-1:0]  s2_su_r, s2_sv_r;

  logic              s3_vld_r, s3_cv_r;
  logic [COMP_W-1:0] s3_y_r;
  logic [PROD_W-1:0] s3_pu_r, s3_pv_r;
  logic [QUO_W-1:0]  qu, qv;
  logic [COMP_W-1:0] au, av;

  logic              out_vld_r;
  logic              out_cv_r;
  logic [COMP_W-1:0] out_y_r, out_u_r, out_v_r;

  for (genvar d = 0; d <= AREA_MAX; d++) begin : g_rcp
    localparam longint RCP = (d == 0) ? 0 : ((longint'(1) << RCP_SHIFT) + d - 1) / d;
    assign rcp_tbl[d] = RCP_W'(RCP);
  end

  assign w_eff = (int'(cell_width) > MAX_CELL_SIDE) ? SIDE_W'(MAX_CELL_SIDE)
                                                    : SIDE_W'(cell_width);
  assign h_eff = (int'(cell_height) > MAX_CELL_SIDE) ? SIDE_W'(MAX_CELL_SIDE)
                                                     : SIDE_W'(cell_height);
  assign area      = AREA_W'(w_eff) * AREA_W'(h_eff);
  assign chroma_en = (w_eff != '0) & (h_eff != '0);

  always_ff @(posedge clk) begin
    rcp_r <= rcp_tbl[area];
  end

  // whole pipe moves together; the queue absorbs the stall
  assign adv       = ~out_vld_r | out_tready;
  assign pop       = adv & pop_valid;
  assign pop_ready = adv;
  assign conv      = rgb_to_yuv(pop_data.red, pop_data.green, pop_data.blue);

  pcys_ram #(
    .WIDTH (3 * COMP_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_tbl (
    .clk   (clk),
    .we    (pop & pop_data.wr),
    .waddr (pop_data.addr[IDX_W-1:0]),
    .wdata (conv),
    .re    (pop & ~pop_data.wr),
    .raddr (pop_data.addr[IDX_W-1:0]),
    .rdata (rd)
  );

  // accumulate
  always_comb begin
    u_add = {1'b0, u_sum_r} + (SUM_W+1)'(rd.u);
    v_add = {1'b0, v_sum_r} + (SUM_W+1)'(rd.v);
    u_acc = u_add[SUM_W] ? '1 : u_add[SUM_W-1:0];
    v_acc = v_add[SUM_W] ? '1 : v_add[SUM_W-1:0];
    u_sum_nxt = u_sum_r;
    v_sum_nxt = v_sum_r;
    if (adv & s1_vld_r & chroma_en) begin
      u_sum_nxt = s1_last_r ? '0 : u_acc;
      v_sum_nxt = s1_last_r ? '0 : v_acc;
    end
  end

  // average: quotient saturated to 8 bits
  assign qu = s3_pu_r[PROD_W-1:RCP_SHIFT];
  assign qv = s3_pv_r[PROD_W-1:RCP_SHIFT];
  assign au = (qu[QUO_W-1:COMP_W] != '0) ? '1 : qu[COMP_W-1:0];
  assign av = (qv[QUO_W-1:COMP_W] != '0) ? '1 : qv[COMP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      u_sum_r   <= '0;
      v_sum_r   <= '0;
    end else begin
      u_sum_r <= u_sum_nxt;
      v_sum_r <= v_sum_nxt;
      if (adv) begin
        s1_vld_r  <= pop & ~pop_data.wr;
        s2_vld_r  <= s1_vld_r;
        s3_vld_r  <= s2_vld_r;
        out_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r <= pop_data.last;
      s2_y_r    <= rd.y;
      s2_cv_r   <= chroma_en & s1_last_r;
      s2_su_r   <= u_acc;
      s2_sv_r   <= v_acc;
      s3_y_r    <= s2_y_r;
      s3_cv_r   <= s2_cv_r;
      s3_pu_r   <= PROD_W'(s2_su_r) * PROD_W'(rcp_r);
      s3_pv_r   <= PROD_W'(s2_sv_r) * PROD_W'(rcp_r);
      out_y_r   <= s3_y_r;
      out_cv_r  <= s3_cv_r;
      out_u_r   <= s3_cv_r ? au : '0;
      out_v_r   <= s3_cv_r ? av : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_v_r, out_u_r, out_y_r};
  assign out_tuser  = out_cv_r;

endmodule

// ===== design/palette_to_yuv_chroma_subsample_unit.sv =====
// Top level of the palette-to-YUV chroma subsampling unit: configuration
// registers, front, request queue and back pipeline. Depends on pcys_pkg and submodules.
//
// Accepts one item per cycle sustained while the output is not stalled. A palette
// write (tuser high) converts RGB to clamped Y/U/V and stores it in the palette RAM;
// it yields no result. A pixel (tuser low) yields one result; its path runs through
// the input register, the four-entry request queue, RAM read, chroma accumulate,
// reciprocal multiply and saturate into the output register. A stalled output
// holds the whole back pipeline and the queue absorbs up to four requests. On a
// pixel with tlast set, tuser of the result is high and U/V carry the cell average.
// Either cell side at zero disables chroma. Palette entries read before being
// written return undefined values. The user must write cell sizes only while idle;
// the block itself does not enforce this.
module palette_to_yuv_chroma_subsample_unit #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_CELL_SIDE   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // palette_slot, red, green, blue, pixel_index
  input  logic        in_tuser,   // operation
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // luma, chroma_u, chroma_v
  output logic        out_tuser,  // chroma_valid
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);
  import pcys_pkg::*;

  logic [SIDE_CFG_W-1:0] width_r, height_r;
  logic                  push_valid, push_ready;
  entry_t                push_data;
  logic                  pop_valid, pop_ready;
  entry_t                pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CELL_SIDE_RST;
      height_r <= CELL_SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_WIDTH:  width_r  <= cfg_wdata;
        CFG_CELL_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pcys_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pcys_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pcys_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_CELL_SIDE   (MAX_CELL_SIDE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cell_width  (width_r),
    .cell_height (height_r),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
